/* rtl/sfp_pkg.sv */
// Package for the switch command frame parser: frame byte codes, defaults and result type.
`timescale 1ns / 1ps

package sfp_pkg;

	localparam int unsigned NUM_SWITCHES_DEF = 3;

	localparam logic [7:0] HDR_BYTE   = 8'h53;  // 'S'
	localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
	localparam logic [7:0] SEP_BYTE   = 8'h3D;  // '='

	localparam int unsigned IDX_OUT_W   = 2;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned LEVEL_OUT_W = 3;
	localparam int unsigned OUT_DATA_W  = 40;

	typedef struct packed {
		logic                   emit;
		logic [IDX_OUT_W-1:0]   switch_index;
		logic [VALUE_W-1:0]     command_value;
		logic [LEVEL_OUT_W-1:0] switch_levels;
	} sfp_result_t;

endpackage

/* rtl/sfp_parser.sv */
// Frame parser state machine with the switch level register; one byte per step.
`timescale 1ns / 1ps

module sfp_parser #(
	parameter int unsigned NUM_SWITCHES = sfp_pkg::NUM_SWITCHES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output sfp_pkg::sfp_result_t result
);
	import sfp_pkg::*;

	localparam int unsigned LVL_W = (NUM_SWITCHES > LEVEL_OUT_W) ? NUM_SWITCHES : LEVEL_OUT_W;
	localparam int unsigned IDX_W = $clog2(LVL_W);

	typedef enum logic [2:0] {
		PH_WAIT_HDR = 3'd0,
		PH_WAIT_SEL = 3'd1,
		PH_WAIT_SEP = 3'd2,
		PH_BYTE0    = 3'd3,
		PH_BYTE1    = 3'd4,
		PH_BYTE2    = 3'd5,
		PH_BYTE3    = 3'd6
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [IDX_W-1:0]   index_q, index_d;
	logic [VALUE_W-1:0] acc_q, acc_d;
	logic [LVL_W-1:0]   levels_q, levels_d;
	logic [7:0]         digit_off;
	logic               digit_ok;
	logic [VALUE_W-1:0] full_value;

	assign digit_off  = rx_byte - DIGIT_BASE;
	assign digit_ok   = (rx_byte >= DIGIT_BASE) && (digit_off < 8'(NUM_SWITCHES));
	assign full_value = {rx_byte, acc_q[23:0]};

	always_comb begin
		phase_d  = phase_q;
		index_d  = index_q;
		acc_d    = acc_q;
		levels_d = levels_q;
		result   = '0;
		case (phase_q)
			PH_WAIT_HDR: begin
				if (rx_byte == HDR_BYTE) begin
					phase_d = PH_WAIT_SEL;
				end
			end
			PH_WAIT_SEL: begin
				if (digit_ok) begin
					index_d = digit_off[IDX_W-1:0];
					phase_d = PH_WAIT_SEP;
				end else begin
					phase_d = PH_WAIT_HDR;
				end
			end
			PH_WAIT_SEP: begin
				if (rx_byte == SEP_BYTE) begin
					acc_d   = '0;
					phase_d = PH_BYTE0;
				end else begin
					phase_d = PH_WAIT_HDR;
				end
			end
			PH_BYTE0: begin
				acc_d[7:0] = rx_byte;
				phase_d    = PH_BYTE1;
			end
			PH_BYTE1: begin
				acc_d[15:8] = rx_byte;
				phase_d     = PH_BYTE2;
			end
			PH_BYTE2: begin
				acc_d[23:16] = rx_byte;
				phase_d      = PH_BYTE3;
			end
			PH_BYTE3: begin
				acc_d   = full_value;
				phase_d = PH_WAIT_HDR;
				// The index was range checked against the switch count when the digit came in.
				levels_d[index_q]    = (full_value != '0);
				result.emit          = 1'b1;
				result.switch_index  = IDX_OUT_W'(index_q);
				result.command_value = full_value;
				result.switch_levels = levels_d[LEVEL_OUT_W-1:0];
			end
			default: begin
				phase_d = PH_WAIT_HDR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT_HDR;
			index_q  <= '0;
			acc_q    <= '0;
			levels_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			index_q  <= index_d;
			acc_q    <= acc_d;
			levels_q <= levels_d;
		end
	end

endmodule

/* rtl/switch_command_frame_parser_top.sv */
// Top level of the switch command frame parser: stream ports, input and result registers.
//
//   channel  direction  payload
//   s_axis   in         tdata[7:0] = rx_byte
//   m_axis   out        tdata[1:0] = switch_index, [33:2] = command_value,
//                       [36:34] = switch_levels, [39:37] = zero
//
// One byte per cycle is taken while the output does not stall; a transferred byte waits in the
// input register until the parser steps on it, and a frame result goes into the output register.
// arst_n clears the parser to hunting for the header, turns all switches off and empties
// both registers. A stalled output holds its result; the input register and the parser
// wait with it, and s_tready drops only while both registers are full and m_tready is low.
`timescale 1ns / 1ps

module switch_command_frame_parser_top #(
	parameter int unsigned NUM_SWITCHES = sfp_pkg::NUM_SWITCHES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // rx_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sfp_pkg::OUT_DATA_W-1:0]     m_tdata    // switch_index, command_value,
	                                                      // switch_levels, zero fill
);
	import sfp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic        advance;
	sfp_result_t result;

	// The parser steps whenever the input register holds a byte and the output register can take what it produces.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	sfp_parser #(
		.NUM_SWITCHES(NUM_SWITCHES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.emit) begin
			out_data_q <= {3'b000, result.switch_levels, result.command_value,
				result.switch_index};
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the switch command frame parser: directed frames, random traffic, self-check.
`timescale 1ns / 1ps

module tb_top;
	import sfp_pkg::*;

	localparam int unsigned NSW         = NUM_SWITCHES_DEF;
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned RAND_ITEMS  = 1400;
	localparam int unsigned DRAIN_EVERY = 350;
	localparam int unsigned TAIL_CYCLES = 8;

	typedef enum logic [2:0] {
		HUNT_HDR, WANT_DIGIT, WANT_SEP, VAL_B0, VAL_B1, VAL_B2, VAL_B3
	} parse_phase_t;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] value;
		logic [2:0]  levels;
	} frame_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        has_exp;
		logic [1:0]  idx;
		logic [31:0] value;
		logic [2:0]  levels;
	} dir_row_t;

	// Directed bytes; a row that closes a frame carries its expected result.
	localparam dir_row_t DIR_ROWS [30] = '{
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{SEP_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'h00, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'h00, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'h00, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'h00, 1'b1, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE + 8'd2, 1'b0, 2'd0, 32'h0, 3'd0},
		'{SEP_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'hFF, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'hFF, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'hFF, 1'b0, 2'd0, 32'h0, 3'd0},
		'{8'hFF, 1'b1, 2'd2, 32'hFFFF_FFFF, 3'b100},
		// A second header while waiting for the digit, a bad digit or a bad separator only drops back to the hunt.
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE - 8'd1, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE + 8'd3, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE + 8'd1, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		// Header bytes inside the value are plain data.
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{DIGIT_BASE + 8'd1, 1'b0, 2'd0, 32'h0, 3'd0},
		'{SEP_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b0, 2'd0, 32'h0, 3'd0},
		'{HDR_BYTE, 1'b1, 2'd1, 32'h5353_5353, 3'b110}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	// Parser state as the testbench tracks it.
	parse_phase_t prs_phase;
	logic [1:0]   prs_sel;
	logic [31:0]  prs_accum;
	logic [2:0]   prs_levels;

	frame_t      frames_due [$];
	frame_t      exp_frame;
	int unsigned errors = 0;
	int unsigned bytes_sent;
	int unsigned quiet_cycles = 0;
	int unsigned rx_stall_left = 0;
	bit          tx_calm;
	bit          rx_calm = 1'b0;

	switch_command_frame_parser_top #(
		.NUM_SWITCHES(NSW)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic bit advance_parser(input logic [7:0] b, output frame_t f);
		bit done;
		done = 1'b0;
		f = '0;
		case (prs_phase)
			HUNT_HDR: begin
				if (b == HDR_BYTE)
					prs_phase = WANT_DIGIT;
			end
			WANT_DIGIT: begin
				if (b >= DIGIT_BASE && b < DIGIT_BASE + NSW) begin
					prs_sel = 2'(b - DIGIT_BASE);
					prs_phase = WANT_SEP;
				end else begin
					prs_phase = HUNT_HDR;
				end
			end
			WANT_SEP: begin
				if (b == SEP_BYTE) begin
					prs_accum = '0;
					prs_phase = VAL_B0;
				end else begin
					prs_phase = HUNT_HDR;
				end
			end
			VAL_B0: begin
				prs_accum[7:0] = prs_accum[7:0] | b;
				prs_phase = VAL_B1;
			end
			VAL_B1: begin
				prs_accum[15:8] = prs_accum[15:8] | b;
				prs_phase = VAL_B2;
			end
			VAL_B2: begin
				prs_accum[23:16] = prs_accum[23:16] | b;
				prs_phase = VAL_B3;
			end
			VAL_B3: begin
				prs_accum[31:24] = prs_accum[31:24] | b;
				prs_phase = HUNT_HDR;
				if (prs_sel < NSW)
					prs_levels[prs_sel] = (prs_accum != 32'd0);
				f.idx = prs_sel;
				f.value = prs_accum;
				f.levels = prs_levels;
				done = 1'b1;
			end
			default: prs_phase = HUNT_HDR;
		endcase
		return done;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = tx_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_tracked(input logic [7:0] b);
		frame_t f;
		send_byte(b);
		if (advance_parser(b, f))
			frames_due.push_back(f);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_value_byte(input int unsigned kind);
		case (kind)
			0, 1: return 8'h00;
			2: return 8'hFF;
			3: begin
				case ($urandom_range(0, 3))
					0: return HDR_BYTE;
					1: return SEP_BYTE;
					2: return DIGIT_BASE;
					default: return DIGIT_BASE + 8'($urandom_range(1, NSW - 1));
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_random_group();
		int unsigned kind;
		int unsigned vkind;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			send_tracked(HDR_BYTE);
			send_tracked(DIGIT_BASE + 8'($urandom_range(0, NSW - 1)));
			send_tracked(SEP_BYTE);
			vkind = $urandom_range(0, 9);
			repeat (4)
				send_tracked(pick_value_byte(vkind));
		end else if (kind < 80) begin
			// Good digit, wrong separator.
			send_tracked(HDR_BYTE);
			send_tracked(DIGIT_BASE + 8'($urandom_range(0, NSW - 1)));
			do
				b = 8'($urandom);
			while (b == SEP_BYTE);
			send_tracked(b);
		end else if (kind < 90) begin
			send_tracked(HDR_BYTE);
			do
				b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h2C, 8'h36));
			while (b >= DIGIT_BASE && b < DIGIT_BASE + NSW);
			send_tracked(b);
		end else begin
			repeat ($urandom_range(1, 4))
				send_tracked(8'($urandom));
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				exp_frame = frames_due.pop_front();
				if (m_tdata[1:0] !== exp_frame.idx) begin
					$display("%0t: switch_index expected %0d actual %0d",
						$time, exp_frame.idx, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[33:2] !== exp_frame.value) begin
					$display("%0t: command_value expected %h actual %h",
						$time, exp_frame.value, m_tdata[33:2]);
					errors++;
				end
				if (m_tdata[36:34] !== exp_frame.levels) begin
					$display("%0t: switch_levels expected %b actual %b",
						$time, exp_frame.levels, m_tdata[36:34]);
					errors++;
				end
				if (m_tdata[39:37] !== 3'b000) begin
					$display("%0t: zero fill expected 000 actual %b", $time, m_tdata[39:37]);
					errors++;
				end
			end
		end
	end

	// Receiver back-pressure, with stretches of steady readiness.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				rx_calm = ~rx_calm;
			if (rx_stall_left > 0) begin
				m_tready <= 1'b0;
				rx_stall_left--;
			end else begin
				m_tready <= 1'b1;
				rx_stall_left = rx_calm ? 0 : pick_gap();
			end
		end
	end

	// Ends the run if no transfer happens on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired with %0d results pending", $time, frames_due.size());
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		frame_t      f;
		int unsigned next_drain;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		bytes_sent = 0;
		tx_calm = 1'b0;
		prs_phase = HUNT_HDR;
		prs_sel = '0;
		prs_accum = '0;
		prs_levels = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_ROWS[i]) begin
			send_byte(DIR_ROWS[i].b);
			// The tracker still runs on every row so the random part starts in step.
			if (advance_parser(DIR_ROWS[i].b, f) || DIR_ROWS[i].has_exp) begin
				if (DIR_ROWS[i].has_exp) begin
					f.idx = DIR_ROWS[i].idx;
					f.value = DIR_ROWS[i].value;
					f.levels = DIR_ROWS[i].levels;
				end
				frames_due.push_back(f);
			end
		end
		drain_results();

		next_drain = bytes_sent + DRAIN_EVERY;
		while (bytes_sent < $size(DIR_ROWS) + RAND_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				tx_calm = ~tx_calm;
			send_random_group();
			if (bytes_sent >= next_drain) begin
				drain_results();
				next_drain = bytes_sent + DRAIN_EVERY;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && frames_due.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
